// File: src/ardf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ardf_pkg;

  // Special characters
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_PROMPT = 8'h3E;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Defaults
  localparam int          BUF_DEPTH_DEF      = 64;
  localparam logic [31:0] CONT_PREFIX_RST    = 32'd725830996;
  localparam logic [2:0]  CONT_PREFIX_LEN_RST = 3'd4;

  // Register indexes
  localparam logic CFG_CONT_PREFIX     = 1'b0;
  localparam logic CFG_CONT_PREFIX_LEN = 1'b1;

  // Prefix bytes compared at most
  localparam int PREFIX_BYTES = 4;

endpackage

`default_nettype wire

// File: src/ardf_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ardf_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: src/at_response_line_deframer_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// AT response line deframer. Cuts a stream of received modem bytes (one per
// input item) into frames: a frame opens with CR LF and its body is stored
// until the closing CR LF, or until '>' followed by a space (prompt frame; the
// '>' is kept). When the body starts with the configured continuation prefix,
// one inner CR LF is skipped and the next line is appended. A completed frame
// is played out one byte per output item with tlast on the final one; an empty
// frame gives a single item with byte_valid low. Bytes that find the store
// full are dropped and frame_truncated is set on every item of that frame.
// An unexpected byte aborts and clears the frame and is re-examined as a
// start byte. While parsing, the input is always ready; at a frame end it
// stops (s_axis_tready low) while the store is read out: each stored byte is
// read from the memory, then loaded into the output register, and a read
// issues only while that register is free, so m_axis_tready can hold it.
// The output register lets the next byte be accepted while the last result
// still waits. The user must write configuration only while idle (unenforced).
module at_response_line_deframer_unit
  import ardf_pkg::*;
#(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config write port
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  // byte input
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // frame output
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic             m_axis_tlast,   // frame_last
  output logic      [1:0]  m_axis_tuser    // [0] byte_valid, [1] frame_truncated
);

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int CW = $clog2(BUF_DEPTH + 1);

  // Controller states
  localparam logic [2:0] ST_WAIT_CR     = 3'd0;
  localparam logic [2:0] ST_WAIT_LF     = 3'd1;
  localparam logic [2:0] ST_STORE       = 3'd2;
  localparam logic [2:0] ST_WAIT_SPACE  = 3'd3;
  localparam logic [2:0] ST_WAIT_END_LF = 3'd4;
  localparam logic [2:0] ST_EMIT        = 3'd5;  // issue store read
  localparam logic [2:0] ST_LOAD        = 3'd6;  // read data -> output reg

  logic [2:0]  state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic        cont_q, cont_d;
  logic        ovf_q, ovf_d;
  logic [PREFIX_BYTES-1:0][7:0] pre_q, pre_d;  // copy of the first body bytes

  logic [31:0] prefix_q;
  logic [2:0]  plen_q;

  logic        out_v_q, out_v_d;
  logic [7:0]  out_data_q, out_data_d;
  logic        out_bv_q, out_bv_d;
  logic        out_last_q, out_last_d;
  logic        out_tr_q, out_tr_d;

  // memory port
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_re;
  logic [7:0]    mem_rdata;

  logic       in_acc;
  logic       out_free;
  logic [7:0] b;
  logic [2:0] plen_eff;
  logic       pfx_match;
  logic [CW-1:0] rd_next;

  assign s_axis_tready = (state_q != ST_EMIT) && (state_q != ST_LOAD);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_v_q || m_axis_tready;
  assign b             = s_axis_tdata;
  assign rd_next       = rd_idx_q + CW'(1);

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = {out_tr_q, out_bv_q};

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q <= CONT_PREFIX_RST;
      plen_q   <= CONT_PREFIX_LEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CONT_PREFIX:     prefix_q <= cfg_data_i;
        CFG_CONT_PREFIX_LEN: plen_q   <= cfg_data_i[2:0];
        default:             ;
      endcase
    end
  end

  // Continuation prefix check; lengths above four clamp to four
  always_comb begin
    plen_eff  = (plen_q > 3'(PREFIX_BYTES)) ? 3'(PREFIX_BYTES) : plen_q;
    pfx_match = (plen_eff != 3'd0) && (cnt_q >= CW'(plen_eff));
    for (int i = 0; i < PREFIX_BYTES; i++) begin
      if ((3'(i) < plen_eff) && (pre_q[i] != prefix_q[8*(PREFIX_BYTES-1-i) +: 8])) begin
        pfx_match = 1'b0;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    rd_idx_d   = rd_idx_q;
    cont_d     = cont_q;
    ovf_d      = ovf_q;
    pre_d      = pre_q;
    out_v_d    = out_v_q && !m_axis_tready;
    out_data_d = out_data_q;
    out_bv_d   = out_bv_q;
    out_last_d = out_last_q;
    out_tr_d   = out_tr_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;

    unique case (state_q)
      ST_WAIT_CR, ST_WAIT_LF, ST_STORE, ST_WAIT_SPACE, ST_WAIT_END_LF: begin
        if (in_acc) begin
          // start byte handling by default: abort and re-examine
          priority if (state_q == ST_WAIT_LF && b == CH_LF) begin
            cnt_d   = '0;
            cont_d  = 1'b0;
            ovf_d   = 1'b0;
            state_d = ST_STORE;
          end else if (state_q == ST_STORE) begin
            if (b == CH_CR) begin
              state_d = ST_WAIT_END_LF;
            end else begin
              if (cnt_q < CW'(BUF_DEPTH)) begin
                mem_we = 1'b1;
                cnt_d  = cnt_q + CW'(1);
                if (cnt_q < CW'(PREFIX_BYTES)) begin
                  pre_d[cnt_q[1:0]] = b;
                end
              end else begin
                ovf_d = 1'b1;
              end
              if (b == CH_PROMPT) begin
                state_d = ST_WAIT_SPACE;
              end
            end
          end else if (state_q == ST_WAIT_SPACE && b == CH_SPACE) begin
            rd_idx_d = '0;
            state_d  = ST_EMIT;
          end else if (state_q == ST_WAIT_END_LF && b == CH_LF) begin
            if (!cont_q && pfx_match) begin
              cont_d  = 1'b1;
              state_d = ST_STORE;
            end else begin
              rd_idx_d = '0;
              state_d  = ST_EMIT;
            end
          end else begin
            cnt_d   = '0;
            cont_d  = 1'b0;
            ovf_d   = 1'b0;
            state_d = (b == CH_CR) ? ST_WAIT_LF : ST_WAIT_CR;
          end
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          if (cnt_q == '0) begin
            // empty frame: one marker item
            out_v_d    = 1'b1;
            out_data_d = '0;
            out_bv_d   = 1'b0;
            out_last_d = 1'b1;
            out_tr_d   = ovf_q;
            cnt_d      = '0;
            cont_d     = 1'b0;
            ovf_d      = 1'b0;
            state_d    = ST_WAIT_CR;
          end else begin
            mem_re  = 1'b1;
            state_d = ST_LOAD;
          end
        end
      end

      ST_LOAD: begin
        // output reg was free when the read issued
        out_v_d    = 1'b1;
        out_data_d = mem_rdata;
        out_bv_d   = 1'b1;
        out_last_d = (rd_next == cnt_q);
        out_tr_d   = ovf_q;
        rd_idx_d   = rd_next;
        if (rd_next == cnt_q) begin
          cnt_d   = '0;
          cont_d  = 1'b0;
          ovf_d   = 1'b0;
          state_d = ST_WAIT_CR;
        end else begin
          state_d = ST_EMIT;
        end
      end

      default: begin
        state_d = ST_WAIT_CR;
      end
    endcase
  end

  assign mem_waddr = cnt_q[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_WAIT_CR;
      cnt_q    <= '0;
      rd_idx_q <= '0;
      cont_q   <= 1'b0;
      ovf_q    <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_idx_q <= rd_idx_d;
      cont_q   <= cont_d;
      ovf_q    <= ovf_d;
      out_v_q  <= out_v_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    pre_q      <= pre_d;
    out_data_q <= out_data_d;
    out_bv_q   <= out_bv_d;
    out_last_q <= out_last_d;
    out_tr_q   <= out_tr_d;
  end

  ardf_ram #(
    .DEPTH (BUF_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (b),
    .re_i    (mem_re),
    .raddr_i (rd_idx_q[AW-1:0]),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire

// File: test/at_response_line_deframer_unit_tb.sv
`timescale 1ns / 1ps

// Stream testbench for the AT response line deframer.
// Bytes go in on the slave side; frame bytes come out on the master side and
// are checked against a local parser model kept in step with every accepted
// input item.
module at_response_line_deframer_unit_tb;
  import ardf_pkg::*;

  localparam int WATCHDOG_CYCLES = 2000;  // cycles with no item moving at all
  localparam int SETTLE_CYCLES   = 16;    // quiet time before a register write
  localparam int END_CYCLES      = 40;    // quiet time before the verdict
  localparam int PHASE_ITEMS     = 45;    // parsed input items per setting

  // Parser states of the local model.
  typedef enum logic [2:0] {
    PH_WAIT_CR,
    PH_WAIT_LF,
    PH_BODY,
    PH_WAIT_SPACE,
    PH_WAIT_END_LF
  } parse_ph_e;

  // One output item: the fields as the block reports them.
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       trunc;
  } line_byte_t;

  // Directed stimulus row: input byte, and where the result is obvious, the
  // single result it must produce.
  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    logic [7:0] w_data;
    logic       w_valid;
    logic       w_last;
    logic       w_trunc;
  } stim_row_t;

  localparam int DIR_ROWS = 31;
  localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
    // junk while waiting for a frame start, both byte extremes
    '{8'hFF,     1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h00,     1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    // empty frame: one item, byte_valid low
    '{CH_CR,     1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{CH_LF,     1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{CH_CR,     1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{CH_LF,     1'b1, 8'h00, 1'b0, 1'b1, 1'b0},
    // bare prompt: '>' is kept, space closes
    '{CH_CR,     1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{CH_LF,     1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{CH_PROMPT, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{CH_SPACE,  1'b1, CH_PROMPT, 1'b1, 1'b1, 1'b0},
    // CR after '>' aborts and restarts; 'A' after that CR aborts again
    '{CH_CR,     1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{CH_LF,     1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{CH_PROMPT, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{CH_CR,     1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h41,     1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    // one-byte line carrying 0xFF
    '{CH_CR,     1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{CH_LF,     1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'hFF,     1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{CH_CR,     1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{CH_LF,     1'b1, 8'hFF, 1'b1, 1'b1, 1'b0},
    // "+CMT" with the reset prefix: inner CR LF skipped, "q" appended
    '{CH_CR,     1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{CH_LF,     1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h2B,     1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h43,     1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h4D,     1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h54,     1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{CH_CR,     1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{CH_LF,     1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h71,     1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{CH_CR,     1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{CH_LF,     1'b0, 8'h00, 1'b0, 1'b0, 1'b0}
  };

  // DUT connections, all inputs known from time zero
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [31:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;    // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // [7:0] out_byte
  logic        m_axis_tlast;         // frame_last
  logic [1:0]  m_axis_tuser;         // [0] byte_valid, [1] frame_truncated

  at_response_line_deframer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Parser model: own copy of registers and frame state
  // ---------------------------------------------------------------------
  logic [31:0] pfx_word;
  logic [2:0]  pfx_len;
  parse_ph_e   parse_ph;
  logic [7:0]  body_mem [BUF_DEPTH_DEF];
  int          body_fill;
  bit          cont_seen;
  bit          ovf_seen;

  line_byte_t  step_beats[$];   // results caused by the byte just parsed
  line_byte_t  expect_q[$];     // results still owed by the block

  int errors      = 0;
  int items_in    = 0;
  int live_items  = 0;          // input items not simply ignored
  int results_in  = 0;
  int frames_out  = 0;
  int trunc_out   = 0;
  int conts       = 0;
  int settings    = 1;          // reset values count as the first setting
  bit jitter_on   = 1'b1;
  int stall_left  = 0;
  int quiet_cycles = 0;

  function automatic void clear_frame();
    body_fill = 0;
    cont_seen = 1'b0;
    ovf_seen  = 1'b0;
  endfunction

  // unexpected byte: drop the frame, look at the byte as a possible start CR
  function automatic void restart(input logic [7:0] b);
    clear_frame();
    parse_ph = (b == CH_CR) ? PH_WAIT_LF : PH_WAIT_CR;
  endfunction

  function automatic void close_frame();
    if (body_fill == 0) begin
      step_beats.push_back('{8'h00, 1'b0, 1'b1, ovf_seen});
    end else begin
      for (int i = 0; i < body_fill; i++) begin
        step_beats.push_back('{body_mem[i], 1'b1, i == body_fill - 1, ovf_seen});
      end
    end
    clear_frame();
    parse_ph = PH_WAIT_CR;
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    int  n;
    bit  hit;
    step_beats.delete();
    case (parse_ph)
      PH_WAIT_LF: begin
        if (b == CH_LF) begin
          clear_frame();
          parse_ph = PH_BODY;
        end else begin
          restart(b);
        end
      end
      PH_BODY: begin
        if (b == CH_CR) begin
          parse_ph = PH_WAIT_END_LF;
        end else begin
          // '>' is stored like any body byte, then waits for its space
          if (body_fill < BUF_DEPTH_DEF) begin
            body_mem[body_fill] = b;
            body_fill++;
          end else begin
            ovf_seen = 1'b1;
          end
          if (b == CH_PROMPT) parse_ph = PH_WAIT_SPACE;
        end
      end
      PH_WAIT_SPACE: begin
        if (b == CH_SPACE) close_frame();
        else restart(b);
      end
      PH_WAIT_END_LF: begin
        if (b == CH_LF) begin
          // lengths above four compare four bytes; too short a body never matches
          n = (pfx_len > 3'd4) ? 4 : int'(pfx_len);
          hit = !cont_seen && n != 0 && body_fill >= n;
          for (int i = 0; i < n; i++) begin
            if (body_mem[i] != pfx_word[31 - 8*i -: 8]) hit = 1'b0;
          end
          if (hit) begin
            cont_seen = 1'b1;
            conts++;
            parse_ph = PH_BODY;
          end else begin
            close_frame();
          end
        end else begin
          restart(b);
        end
      end
      default: restart(b);
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------
  // Called at a falling edge; returns at the falling edge after the byte was
  // taken, with tvalid still high so back-to-back bytes need no toggle.
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input line_byte_t want = '0);
    int gap;
    gap = (jitter_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    items_in++;
    if (!(parse_ph == PH_WAIT_CR && b != CH_CR)) live_items++;
    deframe_byte(b);
    if (typed) begin
      expect_q.push_back(want);
    end else begin
      foreach (step_beats[i]) expect_q.push_back(step_beats[i]);
    end
    @(negedge clk_i);
  endtask

  // byte with a good chance of being one of the framing characters
  function automatic logic [7:0] any_byte();
    case ($urandom_range(0, 11))
      0:       return CH_CR;
      1:       return CH_LF;
      2:       return CH_PROMPT;
      3:       return CH_SPACE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // body text: mostly plain bytes, now and then a stray framing byte
  task automatic send_text(input int n);
    logic [7:0] b;
    repeat (n) begin
      if ($urandom_range(0, 11) == 0) begin
        b = any_byte();
      end else begin
        do b = 8'($urandom_range(0, 255)); while (b == CH_CR || b == CH_PROMPT);
      end
      send_byte(b);
    end
  endtask

  // mostly short lines; some long enough to overrun the store
  function automatic int body_len();
    return ($urandom_range(0, 11) == 0) ? $urandom_range(58, 72) : $urandom_range(0, 10);
  endfunction

  task automatic run_random(input int budget);
    int stop_at;
    int pick;
    int n;
    logic [7:0] term;
    logic [7:0] b;
    stop_at = live_items + budget;
    while (live_items < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        // well-formed frame: plain line, two-line message or prompt
        send_byte(CH_CR);
        send_byte(CH_LF);
        if (pick >= 35 && pick < 55) begin
          n = (pfx_len > 3'd4) ? 4 : int'(pfx_len);
          // sometimes only part of the prefix, so the body is too short
          if ($urandom_range(0, 3) == 0) n = $urandom_range(0, n);
          for (int i = 0; i < n; i++) send_byte(pfx_word[31 - 8*i -: 8]);
          send_text(body_len());
          send_byte(CH_CR);
          send_byte(CH_LF);
        end
        send_text(body_len());
        if (pick >= 55) begin
          send_byte(CH_PROMPT);
          send_byte(CH_SPACE);
        end else begin
          send_byte(CH_CR);
          send_byte(CH_LF);
        end
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 6)) send_byte(any_byte());
      end else begin
        // frame broken by a wrong byte after CR or after '>'
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_text($urandom_range(0, 6));
        term = $urandom_range(0, 1) ? CH_CR : CH_PROMPT;
        send_byte(term);
        do b = any_byte(); while (b == ((term == CH_CR) ? CH_LF : CH_SPACE));
        send_byte(b);
      end
    end
    // leave the parser waiting for a start CR: end any body with CR, abort the rest
    while (parse_ph != PH_WAIT_CR) send_byte((parse_ph == PH_BODY) ? CH_CR : 8'h5A);
  endtask

  // stop sending and let every owed result come out
  task automatic drain_out(input int settle);
    s_axis_tvalid <= 1'b0;
    while (expect_q.size() != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic set_prefix(input logic [31:0] word, input logic [2:0] len);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_CONT_PREFIX;
    cfg_data_i <= word;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_CONT_PREFIX_LEN;
    cfg_data_i <= {29'd0, len};
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    pfx_word = word;
    pfx_len  = len;
    settings++;
  endtask

  // ---------------------------------------------------------------------
  // Output side: random stall bursts, switched off for the last stretch
  // ---------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!jitter_on) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 4) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left = $urandom_range(0, 3);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // each accepted result against the oldest owed one
  always @(posedge clk_i) begin
    line_byte_t got;
    line_byte_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]};
      results_in++;
      if (got.last) begin
        frames_out++;
        if (got.trunc) trunc_out++;
      end
      if (expect_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result byte %h valid %b last %b trunc %b",
                 $time, got.data, got.valid, got.last, got.trunc);
      end else begin
        want = expect_q.pop_front();
        if (got.data !== want.data || got.valid !== want.valid ||
            got.last !== want.last || got.trunc !== want.trunc) begin
          errors++;
          $display("%0t: mismatch expected byte %h valid %b last %b trunc %b",
                   $time, want.data, want.valid, want.last, want.trunc);
          $display("%0t:          actual   byte %h valid %b last %b trunc %b",
                   $time, got.data, got.valid, got.last, got.trunc);
        end
      end
    end
  end

  // no item moving on either side for too long means the block hung
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t: timeout, %0d results still owed", $time, expect_q.size());
      $display("at_response_line_deframer_unit_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    pfx_word = CONT_PREFIX_RST;
    pfx_len  = CONT_PREFIX_LEN_RST;
    parse_ph = PH_WAIT_CR;
    clear_frame();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part, reset register values
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_byte(DIR_TAB[i].rx, DIR_TAB[i].typed,
                '{DIR_TAB[i].w_data, DIR_TAB[i].w_valid, DIR_TAB[i].w_last,
                  DIR_TAB[i].w_trunc});
    end
    run_random(PHASE_ITEMS);

    // all-ones prefix, length above four (compares four)
    drain_out(SETTLE_CYCLES);
    set_prefix(32'hFFFF_FFFF, 3'd7);
    run_random(PHASE_ITEMS);

    // continuation off
    drain_out(SETTLE_CYCLES);
    set_prefix(32'h0000_0000, 3'd0);
    run_random(PHASE_ITEMS);

    drain_out(SETTLE_CYCLES);
    set_prefix($urandom, 3'd5);
    run_random(PHASE_ITEMS);

    // last stretch: short prefix, both sides at full rate
    drain_out(SETTLE_CYCLES);
    jitter_on = 1'b0;
    set_prefix($urandom, 3'($urandom_range(1, 3)));
    run_random(PHASE_ITEMS);

    drain_out(END_CYCLES);
    $display("covered %0d bytes in (%0d parsed), %0d results in %0d frames",
             items_in, live_items, results_in, frames_out);
    $display("%0d truncated frames, %0d two-line joins, %0d prefix settings",
             trunc_out, conts, settings);
    if (errors == 0) begin
      $display("at_response_line_deframer_unit_tb OK");
    end else begin
      $display("at_response_line_deframer_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
